// ===== rtl/i2cem_pkg.sv =====
// Shared types and constants for the I2C EEPROM master sequencer.
// Used by the front decoder, the command queue, the bus sequencer and the top level.
// No dependencies.
package i2cem_pkg;

  localparam int BufDepth = 8;
  localparam int IdxW     = 3;
  localparam int CntW     = 4;
  localparam int ByteW    = 8;
  localparam int TickW    = 8;

  // Item kinds as carried on the input tuser field.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // One classified item waiting in the queue between front and back.
  typedef struct packed {
    op_t               op;
    logic              load_ok;
    logic [ByteW-1:0]  dev;
    logic [ByteW-1:0]  sub;
    logic [CntW-1:0]   cnt;
    logic [IdxW-1:0]   idx;
    logic [ByteW-1:0]  data;
    logic              sda;
  } q_entry_t;

  // One result; the last member sits in bit 0 once packed.
  typedef struct packed {
    logic [IdxW-1:0]   read_index;
    logic [ByteW-1:0]  read_data;
    logic              read_valid;
    logic              status;
    logic              done_res;
    logic              busy_res;
    logic              sda_out;
    logic              scl;
  } result_t;

endpackage

// ===== rtl/i2c_eeprom_master_sequencer.sv =====
// Top level of the I2C EEPROM master sequencer: configuration register,
// front decoder, command queue and bus sequencer. Depends on i2cem_pkg,
// i2cem_front, i2cem_fifo and i2cem_back.
//
//   Channel  Direction  Handshake            Payload
//   in_      slave      in_tvalid/in_tready  tuser action, tdata item fields
//   out_     master     out_tvalid/tready    tdata one result per input beat
//   cfg_     slave      cfg_valid/cfg_ready  cfg_data = phase_ticks
//
// Every input beat produces exactly one result beat, in order. A beat goes
// through the front decoder into the command queue in the cycle it is
// accepted; the sequencer takes one queued beat per cycle whenever its
// output register is empty or being drained, so the sustained rate is one
// beat per clock; a beat sits in the queue, then in the output register.
// Stalls on the result side back up into the queue, and in_tready drops
// only when the queue is full. Reset is synchronous and active low; it
// returns the bus to idle with both lines released and sets phase_ticks
// to 5. The configuration register is always ready and must only be
// written while the block is idle.
module i2c_eeprom_master_sequencer #(
  parameter int FIFO_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // tuser: action[1:0]
  input  logic [1:0]  in_tuser,
  // tdata: device_addr[7:0], sub_addr[15:8], byte_count[19:16],
  //        buffer_index[22:20], data_in[30:23], sda_in[31]
  input  logic [31:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: scl[0], sda_out[1], busy_res[2], done_res[3], status[4],
  //        read_valid[5], read_data[13:6], read_index[16:14], zero above
  output logic [23:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import i2cem_pkg::*;

  localparam logic [TickW-1:0] PhaseTicksReset = TickW'(5);

  logic [TickW-1:0] phase_ticks_r;
  logic             q_full;
  logic             q_push;
  q_entry_t         q_in;
  logic             q_pop;
  logic             q_valid;
  q_entry_t         q_head;
  result_t          result;

  // Phase divider setting, one write beat at a time.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PhaseTicksReset;
    end else if (cfg_valid) begin
      phase_ticks_r <= cfg_data;
    end
  end

  i2cem_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_in)
  );

  i2cem_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (q_head)
  );

  i2cem_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .phase_ticks (phase_ticks_r),
    .head_valid  (q_valid),
    .head_entry  (q_head),
    .pop         (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_result  (result)
  );

  // The packed result puts scl in bit 0; pad the upper seven bits with zeros.
  assign out_tdata = {(24 - $bits(result_t))'(0), result};

endmodule

// ===== rtl/i2cem_front.sv =====
// Front end: unpacks an input beat and classifies it into a queue entry.
// Depends on i2cem_pkg.
module i2cem_front (
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,
  input  logic [1:0]            in_tuser,
  input  logic                  q_full,
  output logic                  q_push,
  output i2cem_pkg::q_entry_t   q_entry
);
  import i2cem_pkg::*;

  logic [CntW-1:0] raw_cnt;
  logic [CntW-1:0] min_cnt;
  op_t             op;

  assign op        = op_t'(in_tuser);
  assign raw_cnt   = in_tdata[19:16];
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // A read of zero bytes reads one; any count saturates at the buffer depth.
  always_comb begin
    min_cnt = raw_cnt;
    if (op == OP_READ && raw_cnt == '0) begin
      min_cnt = CntW'(1);
    end
    if (min_cnt > CntW'(BufDepth)) begin
      min_cnt = CntW'(BufDepth);
    end
  end

  always_comb begin
    q_entry.op      = op;
    q_entry.load_ok = ({1'b0, in_tdata[22:20]} < (IdxW + 1)'(BufDepth));
    q_entry.dev     = in_tdata[7:0];
    q_entry.sub     = in_tdata[15:8];
    q_entry.cnt     = min_cnt;
    q_entry.idx     = in_tdata[22:20];
    q_entry.data    = in_tdata[30:23];
    q_entry.sda     = in_tdata[31];
  end

endmodule

// ===== rtl/i2cem_fifo.sv =====
// Short command queue between the front decoder and the bus sequencer.
// Depends on i2cem_pkg for the entry type.
module i2cem_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  i2cem_pkg::q_entry_t   push_entry,
  output logic                  full,
  input  logic                  pop,
  output logic                  head_valid,
  output i2cem_pkg::q_entry_t   head_entry
);
  import i2cem_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntQ = $clog2(DEPTH + 1);

  q_entry_t        slot_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntQ-1:0] fill_r, fill_nxt;

  assign full       = (fill_r == CntQ'(DEPTH));
  assign head_valid = (fill_r != '0);
  assign head_entry = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + CntQ'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - CntQ'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== rtl/i2cem_back.sv =====
// Back end: quarter-bit I2C bus sequencer, write buffer and output register.
// Depends on i2cem_pkg.
module i2cem_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [i2cem_pkg::TickW-1:0]   phase_ticks,
  input  logic                          head_valid,
  input  i2cem_pkg::q_entry_t           head_entry,
  output logic                          pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output i2cem_pkg::result_t            out_result
);
  import i2cem_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_START   = 10'b00_0000_0010,
    ST_TX_DEV  = 10'b00_0000_0100,
    ST_TX_SUB  = 10'b00_0000_1000,
    ST_RESTART = 10'b00_0001_0000,
    ST_TX_DEVR = 10'b00_0010_0000,
    ST_TX_DATA = 10'b00_0100_0000,
    ST_RX_DATA = 10'b00_1000_0000,
    ST_RX_ACK  = 10'b01_0000_0000,
    ST_STOP    = 10'b10_0000_0000
  } state_t;

  state_t           state_r, state_nxt;
  logic [TickW-1:0] phase_r, phase_nxt;
  logic [1:0]       quarter_r, quarter_nxt;
  logic [3:0]       bit_r, bit_nxt;
  logic [ByteW-1:0] shift_r, shift_nxt;
  logic [CntW-1:0]  pos_r, pos_nxt;
  logic             rmode_r, rmode_nxt;
  logic [ByteW-1:0] dev_r, dev_nxt;
  logic [ByteW-1:0] sub_r, sub_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic             ack_r, ack_nxt;
  logic [ByteW-1:0] buf_r [BufDepth];
  logic             out_valid_r;
  result_t          out_r, res;

  logic [TickW-1:0] pt;
  logic [TickW:0]   phase_inc;
  logic             expire;
  logic             is_tx;
  logic             tx_nxt;
  logic             q_high;
  logic [CntW-1:0]  pos_inc;
  logic [IdxW-1:0]  buf_addr;
  logic [ByteW-1:0] buf_word;

  assign pop        = head_valid && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_result = out_r;

  assign pt        = (phase_ticks == '0) ? TickW'(1) : phase_ticks;
  assign phase_inc = {1'b0, phase_r} + (TickW + 1)'(1);
  assign expire    = (phase_inc >= {1'b0, pt});
  assign is_tx     = (state_r == ST_TX_DEV) || (state_r == ST_TX_SUB) ||
                     (state_r == ST_TX_DEVR) || (state_r == ST_TX_DATA);
  assign pos_inc   = pos_r + CntW'(1);

  // The only buffer read: slot zero on entry to data, otherwise the next slot.
  assign buf_addr = (state_r == ST_TX_SUB) ? '0 : pos_inc[IdxW-1:0];
  assign buf_word = buf_r[buf_addr];

  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    quarter_nxt = quarter_r;
    bit_nxt     = bit_r;
    shift_nxt   = shift_r;
    pos_nxt     = pos_r;
    rmode_nxt   = rmode_r;
    dev_nxt     = dev_r;
    sub_nxt     = sub_r;
    count_nxt   = count_r;
    ack_nxt     = ack_r;
    res         = '0;

    case (head_entry.op)
      OP_LOAD: begin
      end
      OP_WRITE, OP_READ: begin
        if (state_r == ST_IDLE) begin
          rmode_nxt   = (head_entry.op == OP_READ);
          dev_nxt     = head_entry.dev;
          sub_nxt     = head_entry.sub;
          count_nxt   = head_entry.cnt;
          ack_nxt     = 1'b0;
          pos_nxt     = '0;
          bit_nxt     = '0;
          shift_nxt   = '0;
          phase_nxt   = '0;
          quarter_nxt = '0;
          state_nxt   = ST_START;
        end
      end
      default: begin
        if (state_r != ST_IDLE) begin
          phase_nxt = phase_inc[TickW-1:0];
          if (expire) begin
            phase_nxt = '0;
            if (quarter_r == 2'd2) begin
              if (is_tx && bit_r >= 4'd8) begin
                ack_nxt = !head_entry.sda;
              end else if (state_r == ST_RX_DATA) begin
                shift_nxt = {shift_r[ByteW-2:0], head_entry.sda};
                if (bit_r == 4'd7) begin
                  res.read_valid = 1'b1;
                  res.read_data  = {shift_r[ByteW-2:0], head_entry.sda};
                  res.read_index = pos_r[IdxW-1:0];
                end
              end
            end
            if (quarter_r == 2'd3) begin
              quarter_nxt = '0;
              // End of a bit: step to the next part of the transaction.
              unique case (state_r)
                ST_START: begin
                  state_nxt = ST_TX_DEV;
                  shift_nxt = dev_r;
                  bit_nxt   = '0;
                end
                ST_RESTART: begin
                  state_nxt = ST_TX_DEVR;
                  shift_nxt = dev_r + ByteW'(1);
                  bit_nxt   = '0;
                end
                ST_TX_DEV, ST_TX_SUB, ST_TX_DEVR, ST_TX_DATA: begin
                  if (bit_r < 4'd8) begin
                    shift_nxt = {shift_r[ByteW-2:0], 1'b0};
                    bit_nxt   = bit_r + 4'd1;
                  end else if (!ack_r) begin
                    state_nxt = ST_STOP;
                  end else if (state_r == ST_TX_DEV) begin
                    state_nxt = ST_TX_SUB;
                    shift_nxt = sub_r;
                    bit_nxt   = '0;
                  end else if (state_r == ST_TX_SUB) begin
                    if (rmode_r) begin
                      state_nxt = ST_RESTART;
                    end else if (count_r == '0) begin
                      state_nxt = ST_STOP;
                    end else begin
                      pos_nxt   = '0;
                      state_nxt = ST_TX_DATA;
                      shift_nxt = buf_word;
                      bit_nxt   = '0;
                    end
                  end else if (state_r == ST_TX_DEVR) begin
                    pos_nxt   = '0;
                    state_nxt = ST_RX_DATA;
                    bit_nxt   = '0;
                    shift_nxt = '0;
                  end else begin
                    pos_nxt = pos_inc;
                    if (pos_inc >= count_r) begin
                      state_nxt = ST_STOP;
                    end else begin
                      shift_nxt = buf_word;
                      bit_nxt   = '0;
                    end
                  end
                end
                ST_RX_DATA: begin
                  bit_nxt = bit_r + 4'd1;
                  if (bit_r + 4'd1 >= 4'd8) begin
                    state_nxt = ST_RX_ACK;
                  end
                end
                ST_RX_ACK: begin
                  pos_nxt = pos_inc;
                  if (pos_inc >= count_r) begin
                    state_nxt = ST_STOP;
                  end else begin
                    state_nxt = ST_RX_DATA;
                    bit_nxt   = '0;
                    shift_nxt = '0;
                  end
                end
                ST_STOP: begin
                  state_nxt    = ST_IDLE;
                  res.done_res = 1'b1;
                  res.status   = !ack_r;
                end
                default: begin
                end
              endcase
            end else begin
              quarter_nxt = quarter_r + 2'd1;
            end
          end
        end
      end
    endcase

    // Line levels for the state reached after this item.
    q_high = (quarter_nxt == 2'd1) || (quarter_nxt == 2'd2);
    tx_nxt = (state_nxt == ST_TX_DEV) || (state_nxt == ST_TX_SUB) ||
             (state_nxt == ST_TX_DEVR) || (state_nxt == ST_TX_DATA);
    res.busy_res = (state_nxt != ST_IDLE);
    if (state_nxt == ST_START || state_nxt == ST_RESTART) begin
      res.scl     = q_high;
      res.sda_out = (quarter_nxt < 2'd2);
    end else if (tx_nxt) begin
      res.scl     = q_high;
      res.sda_out = (bit_nxt < 4'd8) ? shift_nxt[ByteW-1] : 1'b1;
    end else if (state_nxt == ST_RX_DATA) begin
      res.scl     = q_high;
      res.sda_out = 1'b1;
    end else if (state_nxt == ST_RX_ACK) begin
      res.scl     = q_high;
      res.sda_out = !({1'b0, pos_nxt} + (CntW + 1)'(1) < {1'b0, count_nxt});
    end else if (state_nxt == ST_STOP) begin
      res.scl     = (quarter_nxt != 2'd0);
      res.sda_out = (quarter_nxt >= 2'd2);
    end else begin
      res.scl     = 1'b1;
      res.sda_out = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= '0;
      quarter_r   <= '0;
      bit_r       <= '0;
      shift_r     <= '0;
      pos_r       <= '0;
      rmode_r     <= 1'b0;
      dev_r       <= '0;
      sub_r       <= '0;
      count_r     <= '0;
      ack_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        state_r   <= state_nxt;
        phase_r   <= phase_nxt;
        quarter_r <= quarter_nxt;
        bit_r     <= bit_nxt;
        shift_r   <= shift_nxt;
        pos_r     <= pos_nxt;
        rmode_r   <= rmode_nxt;
        dev_r     <= dev_nxt;
        sub_r     <= sub_nxt;
        count_r   <= count_nxt;
        ack_r     <= ack_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r <= res;
    end
    if (pop && head_entry.op == OP_LOAD && head_entry.load_ok) begin
      buf_r[head_entry.idx] <= head_entry.data;
    end
  end

  a_state_onehot : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state is not one-hot");

  a_bit_range : assert property (@(posedge clk) disable iff (!rst_n)
    bit_r <= 4'd8)
    else $error("bit counter ran past the acknowledge bit");

  a_pos_range : assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= count_r)
    else $error("byte position ran past the transfer count");

  a_rx_only : assert property (@(posedge clk) disable iff (!rst_n)
    pop && res.read_valid |-> state_r == ST_RX_DATA && quarter_r == 2'd2)
    else $error("received byte reported outside a read data bit");

  a_done_idle : assert property (@(posedge clk) disable iff (!rst_n)
    pop && res.done_res |=> state_r == ST_IDLE && out_valid_r && out_r.done_res)
    else $error("completion not followed by idle state");

endmodule

// ===== sim/i2c_eeprom_master_sequencer_test.sv =====
// Self-checking bench for i2c_eeprom_master_sequencer: tick, load and command beats go in,
// every result beat is predicted by a beat-accurate model of the bus master and compared.
// Depends on i2cem_pkg and the RTL of the block; needs no files or arguments.
module i2c_eeprom_master_sequencer_test;
  import i2cem_pkg::*;

  // Steps of the bus master, one per kind of bit it is putting on the wire.
  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_START,
    SQ_DEV,
    SQ_SUB,
    SQ_RESTART,
    SQ_DEVR,
    SQ_WDATA,
    SQ_RDATA,
    SQ_RACK,
    SQ_STOP
  } seq_state_e;

  // How the simulated slave answers on the acknowledge bits.
  typedef enum int {
    ANSWER_ACK,
    ANSWER_NACK,
    ANSWER_MOSTLY,
    ANSWER_NOISE
  } answer_e;

  // One input beat, field by field.
  typedef struct {
    op_t        op;
    logic [7:0] dev;
    logic [7:0] sub;
    logic [3:0] cnt;
    logic [2:0] idx;
    logic [7:0] data;
    logic       sda;
  } beat_t;

  // One row of the directed table. When run is set, the bench keeps ticking after the row
  // until the bus is idle again, answering every acknowledge bit with the row's sda level.
  typedef struct {
    beat_t   b;
    int      pt_before;
    bit      run;
    bit      typed;
    result_t exp_out;
  } row_t;

  // Result beats that can be read off at a glance: bus idle with both lines released, and
  // the beat that accepts a command (start bit, quarter 0: SCL low, SDA still high).
  localparam result_t OUT_IDLE  = 17'b000_00000000_0_0_0_0_1_1;
  localparam result_t OUT_ARMED = 17'b000_00000000_0_0_0_1_1_0;

  // Bytes preloaded into the page buffer, slot 0 in the low byte.
  localparam logic [63:0] FILL_BYTES = 64'hFE7F_5AA5_0180_FF00;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic [1:0]  in_tuser   = '0;
  logic [31:0] in_tdata   = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data   = '0;

  // Model of the master: its own copy of the phase length and of all sequencing state.
  seq_state_e  sq;
  logic [7:0]  q_ticks_cfg;
  logic [7:0]  tick_cnt;
  logic [1:0]  qtr;
  logic [3:0]  bit_cnt;
  logic [7:0]  shreg;
  logic [3:0]  byte_pos;
  logic [7:0]  page [BufDepth];
  logic        rd_mode;
  logic [7:0]  tgt_dev;
  logic [7:0]  tgt_sub;
  logic [3:0]  tgt_cnt;
  logic        acked;

  result_t     bus_outputs_due [$];
  int          errors       = 0;
  int          beats_checked = 0;
  int          beats_sent   = 0;
  bit          no_gaps      = 1'b0;

  i2c_eeprom_master_sequencer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic reset_model();
    sq          = SQ_IDLE;
    q_ticks_cfg = 8'd5;
    tick_cnt    = '0;
    qtr         = '0;
    bit_cnt     = '0;
    shreg       = '0;
    byte_pos    = '0;
    rd_mode     = 1'b0;
    tgt_dev     = '0;
    tgt_sub     = '0;
    tgt_cnt     = '0;
    acked       = 1'b0;
    foreach (page[i]) page[i] = '0;
  endtask

  function automatic bit is_sending(seq_state_e s);
    return s == SQ_DEV || s == SQ_SUB || s == SQ_DEVR || s == SQ_WDATA;
  endfunction

  function automatic void start_byte(seq_state_e s, logic [7:0] value);
    sq      = s;
    shreg   = value;
    bit_cnt = '0;
  endfunction

  // Called at the end of quarter 3: picks the next bit of the transaction. A sent byte takes
  // nine bits, the ninth being the slave's acknowledge. Returns 1 when the stop bit ends.
  function automatic bit finish_bit();
    bit ended = 1'b0;
    case (sq)
      SQ_START:   start_byte(SQ_DEV, tgt_dev);
      SQ_RESTART: start_byte(SQ_DEVR, tgt_dev + 8'd1);
      SQ_DEV, SQ_SUB, SQ_DEVR, SQ_WDATA: begin
        if (bit_cnt < 4'd8) begin
          shreg   = shreg << 1;
          bit_cnt = bit_cnt + 4'd1;
        end else if (!acked) begin
          sq = SQ_STOP;
        end else if (sq == SQ_DEV) begin
          start_byte(SQ_SUB, tgt_sub);
        end else if (sq == SQ_SUB) begin
          if (rd_mode) begin
            sq = SQ_RESTART;
          end else if (tgt_cnt == 4'd0) begin
            sq = SQ_STOP;
          end else begin
            byte_pos = '0;
            start_byte(SQ_WDATA, page[0]);
          end
        end else if (sq == SQ_DEVR) begin
          byte_pos = '0;
          sq       = SQ_RDATA;
          bit_cnt  = '0;
          shreg    = '0;
        end else begin
          byte_pos = byte_pos + 4'd1;
          if (byte_pos >= tgt_cnt) sq = SQ_STOP;
          else start_byte(SQ_WDATA, page[byte_pos[2:0]]);
        end
      end
      SQ_RDATA: begin
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= 4'd8) sq = SQ_RACK;
      end
      SQ_RACK: begin
        byte_pos = byte_pos + 4'd1;
        if (byte_pos >= tgt_cnt) begin
          sq = SQ_STOP;
        end else begin
          sq      = SQ_RDATA;
          bit_cnt = '0;
          shreg   = '0;
        end
      end
      SQ_STOP: begin
        sq    = SQ_IDLE;
        ended = 1'b1;
      end
      default: ;
    endcase
    return ended;
  endfunction

  // Applies one input beat to the model and returns the result beat it must produce.
  function automatic result_t bus_step(beat_t b);
    result_t    r = '0;
    logic [7:0] span;
    logic [3:0] n;
    logic       hi;
    case (b.op)
      // The slot index has three bits, so every load lands in the buffer.
      OP_LOAD: page[b.idx] = b.data;
      OP_WRITE, OP_READ: begin
        // A command that arrives while a transaction runs is dropped.
        if (sq == SQ_IDLE) begin
          rd_mode = (b.op == OP_READ);
          n = b.cnt;
          if (rd_mode && n == 4'd0) n = 4'd1;
          if (n > CntW'(BufDepth)) n = CntW'(BufDepth);
          tgt_dev  = b.dev;
          tgt_sub  = b.sub;
          tgt_cnt  = n;
          acked    = 1'b0;
          byte_pos = '0;
          bit_cnt  = '0;
          shreg    = '0;
          tick_cnt = '0;
          qtr      = '0;
          sq       = SQ_START;
        end
      end
      default: begin
        if (sq != SQ_IDLE) begin
          span = (q_ticks_cfg == 8'd0) ? 8'd1 : q_ticks_cfg;
          tick_cnt = tick_cnt + 8'd1;
          if (tick_cnt >= span) begin
            tick_cnt = '0;
            // SDA is sampled at the end of the second high quarter.
            if (qtr == 2'd2) begin
              if (is_sending(sq) && bit_cnt >= 4'd8) begin
                acked = !b.sda;
              end else if (sq == SQ_RDATA) begin
                shreg = {shreg[6:0], b.sda};
                if (bit_cnt == 4'd7) begin
                  r.read_valid = 1'b1;
                  r.read_data  = shreg;
                  r.read_index = byte_pos[2:0];
                end
              end
            end
            if (qtr == 2'd3) begin
              qtr = '0;
              if (finish_bit()) begin
                r.done_res = 1'b1;
                r.status   = !acked;
              end
            end else begin
              qtr = qtr + 2'd1;
            end
          end
        end
      end
    endcase

    // Line levels for the state after this beat.
    hi = (qtr == 2'd1) || (qtr == 2'd2);
    case (sq)
      SQ_START, SQ_RESTART: begin
        r.scl     = hi;
        r.sda_out = (qtr < 2'd2);
      end
      SQ_DEV, SQ_SUB, SQ_DEVR, SQ_WDATA: begin
        r.scl     = hi;
        r.sda_out = (bit_cnt < 4'd8) ? shreg[7] : 1'b1;
      end
      SQ_RDATA: begin
        r.scl     = hi;
        r.sda_out = 1'b1;
      end
      SQ_RACK: begin
        // The master acknowledges every received byte but the last one.
        r.scl     = hi;
        r.sda_out = ({1'b0, byte_pos} + 5'd1 < {1'b0, tgt_cnt}) ? 1'b0 : 1'b1;
      end
      SQ_STOP: begin
        r.scl     = (qtr != 2'd0);
        r.sda_out = (qtr >= 2'd2);
      end
      default: begin
        r.scl     = 1'b1;
        r.sda_out = 1'b1;
      end
    endcase
    r.busy_res = (sq != SQ_IDLE);
    return r;
  endfunction

  function automatic beat_t any_beat(op_t op);
    beat_t b;
    b.op   = op;
    b.dev  = 8'($urandom);
    b.sub  = 8'($urandom);
    b.cnt  = 4'($urandom);
    b.idx  = 3'($urandom);
    b.data = 8'($urandom);
    b.sda  = 1'($urandom);
    return b;
  endfunction

  // SDA level the simulated slave puts on the line for the next tick. Only acknowledge
  // bits follow the answer mode; every other bit, read data included, is random.
  function automatic logic line_answer(answer_e mode);
    if (is_sending(sq) && bit_cnt >= 4'd8) begin
      case (mode)
        ANSWER_ACK:    return 1'b0;
        ANSWER_NACK:   return 1'b1;
        ANSWER_MOSTLY: return ($urandom_range(0, 5) == 0);
        default:       return 1'($urandom);
      endcase
    end
    return 1'($urandom);
  endfunction

  function automatic row_t dir_row(op_t op, logic [7:0] dev, logic [7:0] sub,
                                   logic [3:0] cnt, logic [2:0] idx, logic [7:0] data,
                                   logic sda, int pt_before, bit run, bit typed,
                                   result_t exp_out);
    row_t row;
    row.b.op      = op;
    row.b.dev     = dev;
    row.b.sub     = sub;
    row.b.cnt     = cnt;
    row.b.idx     = idx;
    row.b.data    = data;
    row.b.sda     = sda;
    row.pt_before = pt_before;
    row.run       = run;
    row.typed     = typed;
    row.exp_out   = exp_out;
    return row;
  endfunction

  task automatic report_mismatch(string field, int want, int got);
    errors++;
    if (errors <= 200)
      $display("result beat %0d: %s expected %0d, got %0d", beats_checked, field, want, got);
  endtask

  // Sends one beat. The model is stepped as the beat is offered: beats are accepted in
  // order and the model does not depend on timing, so the expectation is ready in time.
  // Entered and left at a falling edge; valid is only lowered for an idle cycle.
  task automatic send_beat(beat_t b, bit typed, result_t typed_out);
    result_t due;
    due = bus_step(b);
    bus_outputs_due.push_back(typed ? typed_out : due);
    while (!no_gaps && $urandom_range(0, 99) < 16) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tuser  <= b.op;
    in_tdata  <= {b.sda, b.data, b.idx, b.cnt, b.sub, b.dev};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  // Ticks until the modeled bus is idle. With mixed set, loads and dropped commands are
  // sprinkled in between the ticks.
  task automatic run_to_idle(answer_e mode, bit mixed);
    beat_t b;
    int    pick;
    while (sq != SQ_IDLE) begin
      pick = mixed ? $urandom_range(0, 99) : 99;
      if (pick < 6) begin
        b = any_beat(OP_LOAD);
      end else if (pick < 10) begin
        b = any_beat($urandom_range(0, 1) ? OP_READ : OP_WRITE);
      end else begin
        b = any_beat(OP_TICK);
        b.sda = line_answer(mode);
      end
      send_beat(b, 1'b0, OUT_IDLE);
    end
  endtask

  // Changes the phase length. The sender holds off until every outstanding result beat
  // has come back, which also means the block has gone idle.
  task automatic set_phase_ticks(logic [7:0] value);
    in_tvalid <= 1'b0;
    while (bus_outputs_due.size() != 0) @(negedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    q_ticks_cfg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // The result side stalls at random, except during the stretch marked by no_gaps.
  always @(negedge clk) out_tready <= no_gaps || ($urandom_range(0, 99) >= 16);

  // Every accepted result beat is compared with the oldest prediction.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata[16:0]);
      if (bus_outputs_due.size() == 0) begin
        report_mismatch("beat with nothing pending", 0, 1);
      end else begin
        want = bus_outputs_due.pop_front();
        if (got.scl !== want.scl) report_mismatch("scl", want.scl, got.scl);
        if (got.sda_out !== want.sda_out) report_mismatch("sda_out", want.sda_out, got.sda_out);
        if (got.busy_res !== want.busy_res)
          report_mismatch("busy_res", want.busy_res, got.busy_res);
        if (got.done_res !== want.done_res)
          report_mismatch("done_res", want.done_res, got.done_res);
        if (got.status !== want.status) report_mismatch("status", want.status, got.status);
        if (got.read_valid !== want.read_valid)
          report_mismatch("read_valid", want.read_valid, got.read_valid);
        if (got.read_data !== want.read_data)
          report_mismatch("read_data", want.read_data, got.read_data);
        if (got.read_index !== want.read_index)
          report_mismatch("read_index", want.read_index, got.read_index);
        if (out_tdata[23:17] !== 7'd0) report_mismatch("padding", 0, out_tdata[23:17]);
      end
      beats_checked++;
    end
  end

  initial begin
    row_t  rows [$];
    beat_t b;
    int    txns;
    int    pick;
    int    first_random;

    reset_model();

    // Directed table. The first part runs at the reset phase length of 5.
    rows.push_back(dir_row(OP_TICK, 8'h00, 8'h00, 4'd0, 3'd0, 8'h00, 1'b0, -1, 0, 1, OUT_IDLE));
    rows.push_back(dir_row(OP_TICK, 8'hFF, 8'hFF, 4'd15, 3'd7, 8'hFF, 1'b1, -1, 0, 1, OUT_IDLE));
    // Fill every buffer slot before anything is written out, so no unset slot is ever sent.
    for (int i = 0; i < BufDepth; i++)
      rows.push_back(dir_row(OP_LOAD, 8'h00, 8'h00, 4'd0, 3'(i), FILL_BYTES[8*i +: 8], 1'b0,
                             -1, 0, 1, OUT_IDLE));
    // Count above the buffer depth saturates; a read offered meanwhile is dropped; the
    // device then refuses its address, so the write ends with stop and a failure status.
    rows.push_back(dir_row(OP_WRITE, 8'hA0, 8'h00, 4'd15, 3'd0, 8'h00, 1'b0, -1, 0, 1, OUT_ARMED));
    rows.push_back(dir_row(OP_READ, 8'hFF, 8'hFF, 4'd1, 3'd0, 8'h00, 1'b0, -1, 0, 1, OUT_ARMED));
    rows.push_back(dir_row(OP_TICK, 8'h00, 8'h00, 4'd0, 3'd0, 8'h00, 1'b1, -1, 1, 0, OUT_IDLE));
    // Fastest phase from here on. Write of zero bytes: both addresses, then stop.
    rows.push_back(dir_row(OP_WRITE, 8'hFE, 8'hFF, 4'd0, 3'd0, 8'h00, 1'b0, 1, 1, 1, OUT_ARMED));
    // Full page write, acknowledged throughout.
    rows.push_back(dir_row(OP_WRITE, 8'h00, 8'h80, 4'd8, 3'd0, 8'h00, 1'b0, -1, 1, 1, OUT_ARMED));
    // Read of zero bytes reads one, and device address 0xFF wraps to 0x00 for the read.
    rows.push_back(dir_row(OP_READ, 8'hFF, 8'h00, 4'd0, 3'd0, 8'h00, 1'b0, -1, 1, 1, OUT_ARMED));
    // Full page read.
    rows.push_back(dir_row(OP_READ, 8'hA0, 8'h7F, 4'd8, 3'd0, 8'h00, 1'b0, -1, 1, 1, OUT_ARMED));
    // A slot loaded while the write is under way goes out with its new value.
    rows.push_back(dir_row(OP_WRITE, 8'hA0, 8'h10, 4'd3, 3'd0, 8'h00, 1'b0, -1, 0, 1, OUT_ARMED));
    rows.push_back(dir_row(OP_LOAD, 8'h00, 8'h00, 4'd0, 3'd2, 8'h3C, 1'b0, -1, 0, 1, OUT_ARMED));
    rows.push_back(dir_row(OP_WRITE, 8'h55, 8'hAA, 4'd5, 3'd0, 8'h00, 1'b0, -1, 1, 1, OUT_ARMED));
    // Slowest phase: a refused read address.
    rows.push_back(dir_row(OP_READ, 8'hA0, 8'h00, 4'd2, 3'd0, 8'h00, 1'b1, 255, 1, 1, OUT_ARMED));
    // A phase length of zero behaves as one.
    rows.push_back(dir_row(OP_TICK, 8'h00, 8'h00, 4'd0, 3'd0, 8'h00, 1'b0, 0, 0, 1, OUT_IDLE));
    rows.push_back(dir_row(OP_WRITE, 8'hA0, 8'h33, 4'd1, 3'd0, 8'h00, 1'b0, -1, 1, 1, OUT_ARMED));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) begin
      if (rows[i].pt_before >= 0) set_phase_ticks(8'(rows[i].pt_before));
      send_beat(rows[i].b, rows[i].typed, rows[i].exp_out);
      if (rows[i].run) run_to_idle(rows[i].b.sda ? ANSWER_NACK : ANSWER_ACK, 1'b0);
    end

    // Random part: phases of one to five transactions, each phase at its own phase length,
    // mostly the fastest so that many complete transactions fit. Transactions are mostly
    // well formed with random addresses, counts and read data; some get refused at a random
    // byte, some see noise on every acknowledge bit.
    txns = 0;
    first_random = beats_sent;
    while (beats_sent - first_random < 550 || txns < 30) begin
      pick = $urandom_range(0, 9);
      set_phase_ticks(pick < 6 ? 8'd1 : (pick == 6 ? 8'd0 : 8'(pick - 5)));
      repeat ($urandom_range(1, 5)) begin
        no_gaps = (txns >= 8 && txns < 14);
        repeat ($urandom_range(0, 2)) send_beat(any_beat(OP_LOAD), 1'b0, OUT_IDLE);
        if ($urandom_range(0, 3) == 0) send_beat(any_beat(OP_TICK), 1'b0, OUT_IDLE);
        b = any_beat($urandom_range(0, 1) ? OP_READ : OP_WRITE);
        if ($urandom_range(0, 3) != 0) b.cnt = 4'($urandom_range(0, 3));
        send_beat(b, 1'b0, OUT_IDLE);
        pick = $urandom_range(0, 9);
        run_to_idle(pick < 6 ? ANSWER_ACK :
                    (pick < 8 ? ANSWER_MOSTLY : (pick < 9 ? ANSWER_NOISE : ANSWER_NACK)), 1'b1);
        txns++;
      end
    end

    in_tvalid <= 1'b0;
    no_gaps = 1'b0;
    while (bus_outputs_due.size() != 0) @(posedge clk);
    // Wait on so that any stray result beat is still caught.
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("i2c_eeprom_master_sequencer: match");
    end else begin
      $display("i2c_eeprom_master_sequencer: mismatch");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest passing run.
  initial begin
    #20000000;
    $display("i2c_eeprom_master_sequencer: mismatch");
    $finish;
  end

endmodule
